[src/ptsg_pkg.sv]
// ----------------------------------------------------------------------------
// ptsg_pkg
// Shared types and constants for the path target safety gate.
// ----------------------------------------------------------------------------
package ptsg_pkg;

    // Fixed field widths
    localparam int MINPT_W  = 7;
    localparam int CFG_W    = 24;
    localparam int AGE_W    = 24;
    localparam int SQ_W     = 50;
    localparam int STATUS_W = 3;
    localparam int PCOUNT_W = 7;
    localparam int PADDR_W  = 4;
    localparam int PDATA_W  = 32;

    localparam logic [SQ_W-1:0]  SQ_MAX  = {SQ_W{1'b1}};
    localparam logic [AGE_W-1:0] AGE_MAX = {AGE_W{1'b1}};

    // Register reset values
    localparam logic [MINPT_W-1:0] MIN_POINTS_RST = 7'd3;
    localparam logic [CFG_W-1:0]   MAX_OFFPATH_RST = 24'd2000;
    localparam logic [CFG_W-1:0]   MAX_JUMP_RST    = 24'd25000;
    localparam logic [CFG_W-1:0]   MAX_AGE_RST     = 24'd3000;

    // Register map (word index)
    typedef enum logic [1:0] {
        REG_MIN_POINTS  = 2'd0,
        REG_MAX_OFFPATH = 2'd1,
        REG_MAX_JUMP    = 2'd2,
        REG_MAX_AGE     = 2'd3
    } reg_idx_t;

    // Input item kinds
    typedef enum logic [1:0] {
        ACT_PATH   = 2'd0,
        ACT_TARGET = 2'd1,
        ACT_TICK   = 2'd2,
        ACT_EVAL   = 2'd3
    } action_t;

    // Evaluation status codes
    typedef enum logic [STATUS_W-1:0] {
        STS_WAITING = 3'd0,
        STS_SHORT   = 3'd1,
        STS_STALE   = 3'd2,
        STS_OFFPATH = 3'd3,
        STS_JUMP    = 3'd4,
        STS_READY   = 3'd5
    } status_t;

    // Tag carried alongside a distance through the pipeline
    typedef struct packed {
        logic vld;
        logic jump;
    } sq_tag_t;

endpackage

[src/path_target_safety_gate.sv]
// ----------------------------------------------------------------------------
// path_target_safety_gate
// Checks a tracked target against a stored reference path and reports a gate.
// ----------------------------------------------------------------------------
// Path point, target point and tick transfers are taken one per cycle while
// the block is idle. An evaluate transfer that reaches the distance search
// holds the input while the stored points are read from the point memory one
// per cycle and go through the three-stage squared distance pipeline, which
// must drain before the status is known. An evaluate settled by the earlier
// checks (waiting, too short, stale) holds the input too, until any target
// jump still in the pipeline has drained. The result then waits in the output
// register until taken, and a further evaluate waits for that register to
// free before the input reopens. Squared distances are compared against the
// squared thresholds. All thresholds are to be written through the APB port
// while the block is idle; the block itself does not enforce this.
// ----------------------------------------------------------------------------
module path_target_safety_gate
    import ptsg_pkg::*;
#(
    parameter int PATH_DEPTH = 64,
    parameter int COORD_BITS = 24
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    // configuration port
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [PADDR_W-1:0]    paddr,
    input  logic [PDATA_W-1:0]    pwdata,
    output logic [PDATA_W-1:0]    prdata,
    output logic                  pready,
    // input channel
    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic [1:0]            s_action,
    input  logic [COORD_BITS-1:0] s_pos_x,
    input  logic [COORD_BITS-1:0] s_pos_y,
    input  logic [COORD_BITS-1:0] s_pos_z,
    input  logic                  s_last_point,
    // result channel
    output logic                  m_valid,
    input  logic                  m_ready,
    output logic [STATUS_W-1:0]   m_status_code,
    output logic                  m_gate_open,
    output logic [PCOUNT_W-1:0]   m_point_count,
    output logic                  m_target_seen,
    output logic [SQ_W-1:0]       m_nearest_dist_sq,
    output logic                  m_nearest_valid,
    output logic [SQ_W-1:0]       m_jump_dist_sq,
    output logic                  m_path_truncated
);

    localparam int AW    = (PATH_DEPTH > 1) ? $clog2(PATH_DEPTH) : 1;
    localparam int CNT_W = $clog2(PATH_DEPTH + 1);
    localparam int CMP_W = (CNT_W > MINPT_W) ? CNT_W : MINPT_W;
    localparam int PT_W  = 3 * COORD_BITS;

    typedef enum logic [3:0] {
        ST_IDLE  = 4'b0001,
        ST_WALK  = 4'b0010,
        ST_DRAIN = 4'b0100,
        ST_DONE  = 4'b1000
    } state_t;

    // Configuration registers
    logic [MINPT_W-1:0] min_points_reg;
    logic [CFG_W-1:0]   max_offpath_reg;
    logic [CFG_W-1:0]   max_jump_reg;
    logic [CFG_W-1:0]   max_age_reg;
    logic [2*CFG_W-1:0] off_sq_reg;
    logic [2*CFG_W-1:0] jmp_sq_reg;
    logic               cfg_wr;

    // Path and target state
    logic [PT_W-1:0]       mem [PATH_DEPTH];
    logic [CNT_W-1:0]      load_index_reg;
    logic [CNT_W-1:0]      stored_count_reg;
    logic                  path_present_reg;
    logic                  overflow_seen_reg;
    logic                  load_over_reg;
    logic                  load_fits;
    logic [COORD_BITS-1:0] tgt_x_reg, tgt_y_reg, tgt_z_reg;
    logic                  target_present_reg;
    logic [SQ_W-1:0]       jump_sq_held_reg;
    logic [AGE_W-1:0]      path_age_reg;
    logic [AGE_W-1:0]      target_age_reg;

    // Evaluation control
    state_t           state_reg, state_next;
    action_t          act;
    logic             s_accept;
    logic             jump_launch;
    logic             eval_walk_reg;
    status_t          eval_status_reg;
    status_t          pre_status;
    logic             pre_walk;
    status_t          fin_status;
    logic [CNT_W-1:0] rd_idx_reg;
    logic             rd_issue;
    logic             rd_vld_reg;
    logic [PT_W-1:0]  rd_data_reg;
    logic [SQ_W-1:0]  nearest_reg;
    logic             out_load;

    // Distance pipeline interface
    sq_tag_t         sq_in_tag, sq_out_tag;
    logic [PT_W-1:0] sq_in_a;
    logic [SQ_W-1:0] sq_dist;
    logic            sq_busy;

    // Output register
    logic                m_valid_reg;
    status_t             m_status_reg;
    logic [PCOUNT_W-1:0] m_count_reg;
    logic                m_target_reg;
    logic [SQ_W-1:0]     m_nearest_reg;
    logic                m_nvalid_reg;
    logic [SQ_W-1:0]     m_jump_reg;
    logic                m_trunc_reg;

    // ------------------------------------------------------------------------
    // APB register file
    assign pready = 1'b1;
    assign cfg_wr = psel & penable & pwrite & pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            min_points_reg  <= MIN_POINTS_RST;
            max_offpath_reg <= MAX_OFFPATH_RST;
            max_jump_reg    <= MAX_JUMP_RST;
            max_age_reg     <= MAX_AGE_RST;
        end else if (cfg_wr) begin
            case (reg_idx_t'(paddr[3:2]))
                REG_MIN_POINTS:  min_points_reg  <= pwdata[MINPT_W-1:0];
                REG_MAX_OFFPATH: max_offpath_reg <= pwdata[CFG_W-1:0];
                REG_MAX_JUMP:    max_jump_reg    <= pwdata[CFG_W-1:0];
                REG_MAX_AGE:     max_age_reg     <= pwdata[CFG_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (reg_idx_t'(paddr[3:2]))
            REG_MIN_POINTS:  prdata = PDATA_W'(min_points_reg);
            REG_MAX_OFFPATH: prdata = PDATA_W'(max_offpath_reg);
            REG_MAX_JUMP:    prdata = PDATA_W'(max_jump_reg);
            REG_MAX_AGE:     prdata = PDATA_W'(max_age_reg);
            default:         prdata = '0;
        endcase
    end

    // Squared thresholds, refreshed every cycle
    always_ff @(posedge aclk) begin
        off_sq_reg <= max_offpath_reg * max_offpath_reg;
        jmp_sq_reg <= max_jump_reg * max_jump_reg;
    end

    // ------------------------------------------------------------------------
    // Input transfer decode
    assign s_ready     = (state_reg == ST_IDLE);
    assign s_accept    = s_valid & s_ready;
    assign act         = action_t'(s_action);
    assign load_fits   = (load_index_reg < CNT_W'(PATH_DEPTH));
    assign jump_launch = s_accept && (act == ACT_TARGET) && target_present_reg;

    // Path load bookkeeping
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            load_index_reg    <= '0;
            stored_count_reg  <= '0;
            path_present_reg  <= 1'b0;
            overflow_seen_reg <= 1'b0;
            load_over_reg     <= 1'b0;
        end else if (s_accept && act == ACT_PATH) begin
            if (s_last_point) begin
                stored_count_reg  <= load_fits ? load_index_reg + CNT_W'(1) : load_index_reg;
                path_present_reg  <= 1'b1;
                overflow_seen_reg <= load_over_reg | ~load_fits;
                load_index_reg    <= '0;
                load_over_reg     <= 1'b0;
            end else if (load_fits) begin
                load_index_reg <= load_index_reg + CNT_W'(1);
            end else begin
                load_over_reg <= 1'b1;
            end
        end
    end

    // Point memory: one write port for loading, one registered read for the walk
    always_ff @(posedge aclk) begin
        if (s_accept && act == ACT_PATH && load_fits) begin
            mem[load_index_reg[AW-1:0]] <= {s_pos_z, s_pos_y, s_pos_x};
        end
        if (rd_issue) begin
            rd_data_reg <= mem[rd_idx_reg[AW-1:0]];
        end
    end

    // Target point
    always_ff @(posedge aclk) begin
        if (s_accept && act == ACT_TARGET) begin
            tgt_x_reg <= s_pos_x;
            tgt_y_reg <= s_pos_y;
            tgt_z_reg <= s_pos_z;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            target_present_reg <= 1'b0;
        end else if (s_accept && act == ACT_TARGET) begin
            target_present_reg <= 1'b1;
        end
    end

    // Ages: cleared by a fresh path or target, saturating on ticks
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            path_age_reg   <= '0;
            target_age_reg <= '0;
        end else if (s_accept) begin
            case (act)
                ACT_PATH: begin
                    if (s_last_point) path_age_reg <= '0;
                end
                ACT_TARGET: begin
                    target_age_reg <= '0;
                end
                ACT_TICK: begin
                    if (path_age_reg != AGE_MAX) path_age_reg <= path_age_reg + AGE_W'(1);
                    if (target_age_reg != AGE_MAX) target_age_reg <= target_age_reg + AGE_W'(1);
                end
                default: ;
            endcase
        end
    end

    // ------------------------------------------------------------------------
    // Distance pipeline, shared by target jumps and the path walk
    always_comb begin
        sq_in_tag.vld  = jump_launch | rd_vld_reg;
        sq_in_tag.jump = jump_launch;
        sq_in_a        = jump_launch ? {s_pos_z, s_pos_y, s_pos_x} : rd_data_reg;
    end

    ptsg_sq_dist #(
        .COORD_BITS (COORD_BITS)
    ) u_sq_dist (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_tag   (sq_in_tag),
        .in_a     (sq_in_a),
        .in_b     ({tgt_z_reg, tgt_y_reg, tgt_x_reg}),
        .out_tag  (sq_out_tag),
        .out_dist (sq_dist),
        .busy     (sq_busy)
    );

    // Jump result lands in order behind any earlier work
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            jump_sq_held_reg <= '0;
        end else if (sq_out_tag.vld && sq_out_tag.jump) begin
            jump_sq_held_reg <= sq_dist;
        end
    end

    // ------------------------------------------------------------------------
    // Early checks, taken on the evaluate transfer
    always_comb begin
        pre_walk   = 1'b0;
        pre_status = STS_WAITING;
        if (!path_present_reg || !target_present_reg) begin
            pre_status = STS_WAITING;
        end else if (CMP_W'(stored_count_reg) < CMP_W'(min_points_reg)) begin
            pre_status = STS_SHORT;
        end else if (path_age_reg > max_age_reg || target_age_reg > max_age_reg) begin
            pre_status = STS_STALE;
        end else begin
            pre_walk = 1'b1;
        end
    end

    assign rd_issue = (state_reg == ST_WALK) && eval_walk_reg &&
                      (rd_idx_reg < stored_count_reg);

    // Sequencer
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:  if (s_accept && act == ACT_EVAL) state_next = ST_WALK;
            ST_WALK:  if (!rd_issue) state_next = ST_DRAIN;
            ST_DRAIN: if (!rd_vld_reg && !sq_busy) state_next = ST_DONE;
            ST_DONE:  if (out_load) state_next = ST_IDLE;
            default:  state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= ST_IDLE;
            rd_vld_reg <= 1'b0;
        end else begin
            state_reg  <= state_next;
            rd_vld_reg <= rd_issue;
        end
    end

    // Walk index, early result and running minimum
    always_ff @(posedge aclk) begin
        if (s_accept && act == ACT_EVAL) begin
            rd_idx_reg      <= '0;
            eval_walk_reg   <= pre_walk;
            eval_status_reg <= pre_status;
            nearest_reg     <= SQ_MAX;
        end else begin
            if (rd_issue) rd_idx_reg <= rd_idx_reg + CNT_W'(1);
            if (sq_out_tag.vld && !sq_out_tag.jump && sq_dist < nearest_reg) begin
                nearest_reg <= sq_dist;
            end
        end
    end

    // Final status once the pipeline is empty
    always_comb begin
        if (!eval_walk_reg) begin
            fin_status = eval_status_reg;
        end else if (nearest_reg > SQ_W'(off_sq_reg)) begin
            fin_status = STS_OFFPATH;
        end else if (jump_sq_held_reg > SQ_W'(jmp_sq_reg)) begin
            fin_status = STS_JUMP;
        end else begin
            fin_status = STS_READY;
        end
    end

    // ------------------------------------------------------------------------
    // Output register
    assign out_load = (state_reg == ST_DONE) && (!m_valid_reg || m_ready);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (out_load) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            m_status_reg  <= fin_status;
            m_count_reg   <= path_present_reg ? PCOUNT_W'(stored_count_reg) : '0;
            m_target_reg  <= target_present_reg;
            m_nearest_reg <= eval_walk_reg ? nearest_reg : '0;
            m_nvalid_reg  <= eval_walk_reg;
            m_jump_reg    <= jump_sq_held_reg;
            m_trunc_reg   <= path_present_reg & overflow_seen_reg;
        end
    end

    assign m_valid           = m_valid_reg;
    assign m_status_code     = m_status_reg;
    assign m_gate_open       = (m_status_reg == STS_READY);
    assign m_point_count     = m_count_reg;
    assign m_target_seen     = m_target_reg;
    assign m_nearest_dist_sq = m_nearest_reg;
    assign m_nearest_valid   = m_nvalid_reg;
    assign m_jump_dist_sq    = m_jump_reg;
    assign m_path_truncated  = m_trunc_reg;

endmodule

[src/ptsg_sq_dist.sv]
// ----------------------------------------------------------------------------
// ptsg_sq_dist
// Three-stage squared distance pipeline: |a-b| per axis, squares, saturated sum.
// ----------------------------------------------------------------------------
module ptsg_sq_dist
    import ptsg_pkg::*;
#(
    parameter int COORD_BITS = 24
) (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  sq_tag_t                 in_tag,
    input  logic [3*COORD_BITS-1:0] in_a,
    input  logic [3*COORD_BITS-1:0] in_b,
    output sq_tag_t                 out_tag,
    output logic [SQ_W-1:0]         out_dist,
    output logic                    busy
);

    localparam int MAG_W = COORD_BITS + 1;
    localparam int SQR_W = 2 * MAG_W;
    localparam int SUM_W = SQR_W + 2;
    localparam int EXT_W = (SUM_W > SQ_W) ? SUM_W : SQ_W + 1;

    logic signed [MAG_W-1:0] diff [3];
    logic [MAG_W-1:0]        mag [3];
    logic [MAG_W-1:0]        mag_reg [3];
    logic [SQR_W-1:0]        sq_reg [3];
    logic [SUM_W-1:0]        sum;
    logic [EXT_W-1:0]        sum_ext;
    logic [SQ_W-1:0]         dist_reg;
    sq_tag_t                 tag1_reg, tag2_reg, tag3_reg;

    // Stage 1: per-axis magnitude of the difference
    always_comb begin
        for (int k = 0; k < 3; k++) begin
            diff[k] = $signed({in_b[k*COORD_BITS + COORD_BITS-1],
                               in_b[k*COORD_BITS +: COORD_BITS]})
                    - $signed({in_a[k*COORD_BITS + COORD_BITS-1],
                               in_a[k*COORD_BITS +: COORD_BITS]});
            mag[k]  = diff[k][MAG_W-1] ? MAG_W'(-diff[k]) : MAG_W'(diff[k]);
        end
    end

    // Stage 3 sum with saturation
    always_comb begin
        sum     = SUM_W'(sq_reg[0]) + SUM_W'(sq_reg[1]) + SUM_W'(sq_reg[2]);
        sum_ext = EXT_W'(sum);
    end

    // Data path registers
    always_ff @(posedge aclk) begin
        for (int k = 0; k < 3; k++) begin
            mag_reg[k] <= mag[k];
            sq_reg[k]  <= mag_reg[k] * mag_reg[k];
        end
        dist_reg <= (sum_ext > EXT_W'(SQ_MAX)) ? SQ_MAX : sum_ext[SQ_W-1:0];
    end

    // Tag pipeline
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tag1_reg <= '0;
            tag2_reg <= '0;
            tag3_reg <= '0;
        end else begin
            tag1_reg <= in_tag;
            tag2_reg <= tag1_reg;
            tag3_reg <= tag2_reg;
        end
    end

    assign out_tag  = tag3_reg;
    assign out_dist = dist_reg;
    assign busy     = tag1_reg.vld | tag2_reg.vld | tag3_reg.vld;

endmodule
